@@ rtl/ranging_timing_register_encoder_macros.svh @@
// Assertion macros shared by the ranging timing register encoder RTL.
`ifndef RANGING_TIMING_REGISTER_ENCODER_MACROS_SVH
`define RANGING_TIMING_REGISTER_ENCODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RTRE_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rtre assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RTRE_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rtre assertion failed");
`else
`define RTRE_ASSERT_IMP(lbl, a, b)
`define RTRE_ASSERT_NXT(lbl, a, b)
`endif
`endif

@@ rtl/rtre_pkg.sv @@
// Types, constants and state encodings of the ranging timing register encoder.
package rtre_pkg;

    localparam int BUDGET_W = 10;
    localparam int PERIOD_W = 16;
    localparam int OSC_W    = 16;
    localparam int CALW_W   = 16;
    localparam int CAL_W    = 10;
    localparam int WORD_W   = 16;
    localparam int PW_W     = 32;

    // serial divider: dividend/quotient shift register, divisor, step counter
    localparam int DIV_W  = 34;
    localparam int DSR_W  = 24;
    localparam int CNT_W  = 6;
    // main-chain dividends are 31 bits, left-aligned in the divider
    localparam int MAIN_W = 31;

    // serial multiplier
    localparam int MUL_B_W   = 10;
    localparam int MUL_CNT_W = 4;

    // normalizer
    localparam int V_W     = 32;
    localparam int MANT_W  = 8;
    localparam int EXPO_W  = 5;

    // budget in us and the shifted budget
    localparam int MS_US_W = 20;
    localparam int US_W    = 18;
    localparam int T_SHIFT = 12;
    localparam int T_W     = US_W + T_SHIFT;

    localparam logic [BUDGET_W-1:0] BUDGET_MIN_MS  = 10'd10;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX_MS  = 10'd200;
    localparam logic [MS_US_W-1:0]  CONT_OFFSET_US = 20'd2500;
    localparam logic [MS_US_W-1:0]  AUTO_OFFSET_US = 20'd4300;
    localparam logic [MAIN_W-1:0]   OSC_NUM        = 31'h4000_0000;
    localparam logic [MUL_B_W-1:0]  PW_SCALE_NUM   = 10'd211;
    localparam logic [DSR_W-1:0]    PW_SCALE_DEN   = 24'd200;

    typedef struct packed {
        logic [BUDGET_W-1:0] budget_ms;
        logic [PERIOD_W-1:0] period_ms;
        logic [OSC_W-1:0]    osc_frequency;
        logic [CALW_W-1:0]   osc_calibration;
    } req_t;

    typedef struct packed {
        logic              valid_res;
        logic              autonomous;
        logic [WORD_W-1:0] config_word_a;
        logic [WORD_W-1:0] config_word_b;
        logic [PW_W-1:0]   period_word;
    } rsp_t;

    // status of a serial unit: busy while stepping, done for one cycle at the end
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_OSC,
        ST_DIV_A,
        ST_DIV_B,
        ST_NORM_B,
        ST_FINISH
    } st_t;

    typedef enum logic [1:0] {
        PW_IDLE,
        PW_MUL_CAL,
        PW_MUL_K,
        PW_DIV
    } pw_st_t;

endpackage

@@ rtl/rtre_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
`include "ranging_timing_register_encoder_macros.svh"
module rtre_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rtre_pkg::DIV_W-1:0]   dividend,
    input  logic [rtre_pkg::DSR_W-1:0]   divisor,
    input  logic [rtre_pkg::CNT_W-1:0]   nbits,
    output rtre_pkg::unit_stat_t         stat,
    output logic [rtre_pkg::DIV_W-1:0]   quotient
);
    import rtre_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] divisor_reg, divisor_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [DSR_W:0]   rem_shift;
    logic [DSR_W:0]   rem_diff;

    always_comb
    begin
        rem_shift    = {rem_reg, dq_reg[DIV_W-1]};
        rem_diff     = rem_shift - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        dq_next      = dq_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = nbits;
            rem_next     = '0;
            dq_next      = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            count_next = count_reg - CNT_W'(1);
            if (rem_shift >= {1'b0, divisor_reg})
            begin
                rem_next = rem_diff[DSR_W-1:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DSR_W-1:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b0};
            end
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        dq_reg      <= dq_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

    `RTRE_ASSERT_IMP(a_div_start_idle, start, !busy_reg)
    `RTRE_ASSERT_IMP(a_div_nbits_nz, start, nbits != '0)
    `RTRE_ASSERT_NXT(a_div_done_pulse, done_reg, !done_reg)
endmodule

@@ rtl/rtre_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
module rtre_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rtre_pkg::DIV_W-1:0]     a,
    input  logic [rtre_pkg::MUL_B_W-1:0]   b,
    output rtre_pkg::unit_stat_t           stat,
    output logic [rtre_pkg::DIV_W-1:0]     product
);
    import rtre_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]     a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = MUL_CNT_W'(MUL_B_W);
            a_next     = a;
            b_next     = b;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next     = {a_reg[DIV_W-2:0], 1'b0};
            b_next     = {1'b0, b_reg[MUL_B_W-1:1]};
            count_next = count_reg - MUL_CNT_W'(1);
            if (count_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;
endmodule

@@ rtl/rtre_norm.sv @@
// Exponent/mantissa normalizer: shift right one bit per cycle until 8 bits remain.
module rtre_norm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rtre_pkg::V_W-1:0]      value,
    output rtre_pkg::unit_stat_t          stat,
    output logic [rtre_pkg::WORD_W-1:0]   word
);
    import rtre_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [V_W-1:0]    v_reg, v_next;
    logic [EXPO_W-1:0] expo_reg, expo_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        expo_next = expo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = value;
            expo_next = '0;
        end
        else if (busy_reg)
        begin
            if (v_reg[V_W-1:MANT_W] != '0)
            begin
                v_next    = {1'b0, v_reg[V_W-1:1]};
                expo_next = expo_reg + EXPO_W'(1);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        expo_reg <= expo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign word      = {(WORD_W-MANT_W)'(expo_reg), v_reg[MANT_W-1:0]};
endmodule

@@ rtl/rtre_pw.sv @@
// Period word unit: period * cal * 211 / 200 on a serial multiplier and divider.
module rtre_pw (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rtre_pkg::PERIOD_W-1:0] period,
    input  logic [rtre_pkg::CAL_W-1:0]    cal,
    output rtre_pkg::unit_stat_t          stat,
    output logic [rtre_pkg::PW_W-1:0]     pw_word
);
    import rtre_pkg::*;

    pw_st_t           state_reg, state_next;
    logic             done_reg, done_next;
    logic [PW_W-1:0]  pw_reg, pw_next;
    logic             mul_start;
    logic [DIV_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    unit_stat_t       mul_stat;
    logic [DIV_W-1:0] mul_product;
    logic             div_start;
    unit_stat_t       div_stat;
    logic [DIV_W-1:0] div_quot;

    rtre_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_product)
    );

    rtre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (PW_SCALE_DEN),
        .nbits    (CNT_W'(DIV_W)),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        pw_next    = pw_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        case (state_reg)
            PW_IDLE:
            begin
                if (start)
                begin
                    mul_start  = 1'b1;
                    mul_a      = DIV_W'(period);
                    mul_b      = cal;
                    state_next = PW_MUL_CAL;
                end
            end
            PW_MUL_CAL:
            begin
                // feed period * cal back for the 211 scale
                mul_a = mul_product;
                mul_b = PW_SCALE_NUM;
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = PW_MUL_K;
                end
            end
            PW_MUL_K:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = PW_DIV;
                end
            end
            PW_DIV:
            begin
                if (div_stat.done)
                begin
                    pw_next    = div_quot[PW_W-1:0];
                    done_next  = 1'b1;
                    state_next = PW_IDLE;
                end
            end
            default:
            begin
                state_next = PW_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PW_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg <= pw_next;
    end

    assign stat.busy = (state_reg != PW_IDLE);
    assign stat.done = done_reg;
    assign pw_word   = pw_reg;
endmodule

@@ rtl/ranging_timing_register_encoder.sv @@
// Top level of the ranging timing register encoder.
//
//   channel  handshake            payload   direction
//   req      req_valid/req_stall  req_t     in
//   rsp      rsp_valid/rsp_stall  rsp_t     out
//
// A valid item runs three 31-step divisions on the shared shift-subtract
// divider (oscillator word, then each range word) and up to 24 normalize
// shifts on the last word; the last word is then captured and the result
// loaded, and the next request can be taken in the cycle after the load.
// The period word runs on its own multiplier/divider pair alongside the
// main chain. An item that fails the budget, mode or oscillator check goes
// straight to the finishing state; a zero divisor shows after the
// oscillator division.
// Reset clears the sequencers and the output valid; no memory to sweep. A
// stalled result waits in the output register while the next item is taken.
`include "ranging_timing_register_encoder_macros.svh"
module ranging_timing_register_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rtre_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rtre_pkg::rsp_t rsp_data
);
    import rtre_pkg::*;

    st_t               state_reg, state_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic [DSR_W-1:0]  d12_reg, d12_next;
    logic              auton_reg, auton_next;
    logic              ok_reg, ok_next;
    logic [WORD_W-1:0] word_a_reg, word_a_next;
    logic [WORD_W-1:0] word_b_reg, word_b_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic               req_accept;
    logic               req_ok;
    logic [MS_US_W-1:0] budget_x1000;
    logic [MS_US_W-1:0] budget_us;
    logic [DSR_W-1:0]   q_low;
    logic [DSR_W-1:0]   m24;
    logic [DSR_W+1:0]   m3;
    logic [DSR_W-1:0]   d12;
    logic [MAIN_W-1:0]  sum_a;
    logic [MAIN_W-1:0]  sum_b;
    logic               rsp_load;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DSR_W-1:0]   div_divisor;
    unit_stat_t         div_stat;
    logic [DIV_W-1:0]   div_quot;
    logic               norm_start;
    unit_stat_t         norm_stat;
    logic [WORD_W-1:0]  norm_word;
    logic [V_W-1:0]     norm_value;
    logic               pw_start;
    unit_stat_t         pw_stat;
    logic [PW_W-1:0]    pw_word;

    rtre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (CNT_W'(MAIN_W)),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    rtre_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .value (norm_value),
        .stat  (norm_stat),
        .word  (norm_word)
    );

    rtre_pw u_pw (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pw_start),
        .period  (req_data.period_ms),
        .cal     (req_data.osc_calibration[CAL_W-1:0]),
        .stat    (pw_stat),
        .pw_word (pw_word)
    );

    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        req_ok = (req_data.budget_ms >= BUDGET_MIN_MS)
              && (req_data.budget_ms <= BUDGET_MAX_MS)
              && (req_data.osc_frequency != '0)
              && ((req_data.period_ms == '0)
                  || (req_data.period_ms > PERIOD_W'(req_data.budget_ms)));

        budget_x1000 = (MS_US_W'(req_data.budget_ms) << 10)
                     - (MS_US_W'(req_data.budget_ms) << 4)
                     - (MS_US_W'(req_data.budget_ms) << 3);
        if (req_data.period_ms == '0)
        begin
            budget_us = budget_x1000 - CONT_OFFSET_US;
        end
        else
        begin
            budget_us = (budget_x1000 - AUTO_OFFSET_US) >> 1;
        end

        // 2304 = 9 << 8: the wrapped macro period is (q * 9 mod 2^24) << 2,
        // so the factor-16 divisor is q * 9 mod 2^24 and factor 12 is 3/4 of it
        q_low = div_quot[DSR_W-1:0];
        m24   = (q_low << 3) + q_low;
        m3    = {1'b0, m24, 1'b0} + {2'b00, m24};
        d12   = m3[DSR_W+1:2];
        sum_a = {1'b0, t_reg} + MAIN_W'(m24[DSR_W-1:1]);
        sum_b = {1'b0, t_reg} + MAIN_W'(d12_reg[DSR_W-1:1]);

        norm_value = div_quot[V_W-1:0] - V_W'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        d12_next     = d12_reg;
        auton_next   = auton_reg;
        ok_next      = ok_reg;
        word_a_next  = word_a_reg;
        word_b_next  = word_b_reg;
        div_start    = 1'b0;
        div_dividend = {OSC_NUM, {(DIV_W-MAIN_W){1'b0}}};
        div_divisor  = DSR_W'(req_data.osc_frequency);
        norm_start   = 1'b0;
        pw_start     = 1'b0;
        rsp_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    auton_next = (req_data.period_ms != '0);
                    t_next     = {budget_us[US_W-1:0], {T_SHIFT{1'b0}}};
                    ok_next    = req_ok;
                    if (req_ok)
                    begin
                        div_start  = 1'b1;
                        pw_start   = (req_data.period_ms != '0);
                        state_next = ST_DIV_OSC;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_OSC:
            begin
                div_dividend = {sum_a, {(DIV_W-MAIN_W){1'b0}}};
                div_divisor  = m24;
                if (div_stat.done)
                begin
                    d12_next = d12;
                    // zero divisor: drop the item as invalid
                    if (d12 == '0)
                    begin
                        ok_next    = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_A;
                    end
                end
            end
            ST_DIV_A:
            begin
                div_dividend = {sum_b, {(DIV_W-MAIN_W){1'b0}}};
                div_divisor  = d12_reg;
                if (div_stat.done)
                begin
                    norm_start = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (div_stat.done)
                begin
                    word_a_next = norm_word;
                    norm_start  = 1'b1;
                    state_next  = ST_NORM_B;
                end
            end
            ST_NORM_B:
            begin
                if (norm_stat.done)
                begin
                    word_b_next = norm_word;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the period word is in and the output slot frees
                if (!pw_stat.busy && (!rsp_valid_reg || !rsp_stall))
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (rsp_load)
        begin
            rsp_next.valid_res     = ok_reg;
            rsp_next.autonomous    = ok_reg && auton_reg;
            rsp_next.config_word_a = ok_reg ? word_a_reg : '0;
            rsp_next.config_word_b = ok_reg ? word_b_reg : '0;
            rsp_next.period_word   = (ok_reg && auton_reg) ? pw_word : '0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        d12_reg    <= d12_next;
        auton_reg  <= auton_next;
        ok_reg     <= ok_next;
        word_a_reg <= word_a_next;
        word_b_reg <= word_b_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `RTRE_ASSERT_IMP(a_norm_a_done, (state_reg == ST_DIV_B) && div_stat.done, !norm_stat.busy)
    `RTRE_ASSERT_IMP(a_load_pw_idle, rsp_load, !pw_stat.busy)
    `RTRE_ASSERT_IMP(a_div_done_state, div_stat.done, (state_reg == ST_DIV_OSC) || (state_reg == ST_DIV_A) || (state_reg == ST_DIV_B))
endmodule

@@ bench/rtre_checker.sv @@
// Predicts each result beat of the ranging timing register encoder and compares it on the response channel.
`timescale 1ns / 1ps

module rtre_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  rtre_pkg::req_t req_data,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  rtre_pkg::rsp_t rsp_data,
    output int             in_flight,
    output int             fail_count,
    output int             checked,
    output int             valid_seen,
    output int             auto_seen
);
    import rtre_pkg::*;

    localparam logic [31:0] MACRO_SCALE  = 32'd2304;
    localparam logic [31:0] MS_TO_US     = 32'd1000;
    localparam logic [31:0] FACTOR_A     = 32'd16;
    localparam logic [31:0] FACTOR_B     = 32'd12;
    localparam logic [31:0] MACRO_SHIFT  = 32'd6;

    rsp_t timing_words_q[$];
    rsp_t want;
    int   mismatches = 0;
    int   beats = 0;
    int   n_valid = 0;
    int   n_auto = 0;

    // Exponent/mantissa word for one divisor factor; returns 0 when the divisor is zero.
    function automatic logic range_word(input logic [31:0] macro, input logic [31:0] factor,
                                        input logic [31:0] t, output logic [15:0] word);
        logic [31:0] d;
        logic [31:0] v;
        logic [7:0]  expo;
        word = '0;
        d = (macro * factor) >> MACRO_SHIFT;
        if (d == 32'd0)
            return 1'b0;
        v = (t + (d >> 1)) / d - 32'd1;
        expo = '0;
        while (v[31:8] != 24'd0)
        begin
            v = v >> 1;
            expo = expo + 8'd1;
        end
        word = {expo, v[7:0]};
        return 1'b1;
    endfunction

    function automatic rsp_t encode_timing(input req_t req);
        rsp_t        r;
        logic [31:0] bud;
        logic [31:0] per;
        logic [31:0] osc;
        logic [31:0] cal;
        logic [31:0] macro;
        logic [31:0] us;
        logic [31:0] t;
        logic [31:0] pw;
        logic [63:0] prod;
        logic [15:0] wa;
        logic [15:0] wb;
        logic        auton;
        r   = '0;
        bud = {22'd0, req.budget_ms};
        per = {16'd0, req.period_ms};
        osc = {16'd0, req.osc_frequency};
        cal = {22'd0, req.osc_calibration[CAL_W-1:0]};
        pw  = '0;
        if (bud < 32'(BUDGET_MIN_MS) || bud > 32'(BUDGET_MAX_MS) || osc == 32'd0)
            return r;
        macro = (MACRO_SCALE * (32'(OSC_NUM) / osc)) >> MACRO_SHIFT;
        us = bud * MS_TO_US;
        if (per == 32'd0)
        begin
            auton = 1'b0;
            us = us - 32'(CONT_OFFSET_US);
        end
        else if (per > bud)
        begin
            auton = 1'b1;
            us = (us - 32'(AUTO_OFFSET_US)) / 32'd2;
            prod = 64'(per) * 64'(cal) * 64'(PW_SCALE_NUM);
            pw = 32'(prod / 64'(PW_SCALE_DEN));
        end
        else
            return r;
        t = us << T_SHIFT;
        if (!range_word(macro, FACTOR_A, t, wa))
            return r;
        if (!range_word(macro, FACTOR_B, t, wb))
            return r;
        r.valid_res     = 1'b1;
        r.autonomous    = auton;
        r.config_word_a = wa;
        r.config_word_b = wb;
        r.period_word   = pw;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("MISMATCH result beat %0d %s: got 0x%0h, want 0x%0h",
                 beats, what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_words_q.delete();
            in_flight  <= 0;
            fail_count <= 0;
            checked    <= 0;
            valid_seen <= 0;
            auto_seen  <= 0;
        end
        else
        begin
            // Pop before push: a beat can never answer a request taken at the same edge.
            if (rsp_valid && !rsp_stall)
            begin
                if (timing_words_q.size() == 0)
                    report_mismatch("with nothing pending", 32'(rsp_data.valid_res), 32'd0);
                else
                begin
                    want = timing_words_q.pop_front();
                    if (rsp_data.valid_res !== want.valid_res)
                        report_mismatch("valid_res", 32'(rsp_data.valid_res),
                                        32'(want.valid_res));
                    if (rsp_data.autonomous !== want.autonomous)
                        report_mismatch("autonomous", 32'(rsp_data.autonomous),
                                        32'(want.autonomous));
                    if (rsp_data.config_word_a !== want.config_word_a)
                        report_mismatch("config_word_a", 32'(rsp_data.config_word_a),
                                        32'(want.config_word_a));
                    if (rsp_data.config_word_b !== want.config_word_b)
                        report_mismatch("config_word_b", 32'(rsp_data.config_word_b),
                                        32'(want.config_word_b));
                    if (rsp_data.period_word !== want.period_word)
                        report_mismatch("period_word", rsp_data.period_word,
                                        want.period_word);
                    if (want.valid_res)
                        n_valid++;
                    if (want.autonomous)
                        n_auto++;
                end
                beats++;
            end
            if (req_valid && !req_stall)
                timing_words_q.push_back(encode_timing(req_data));
            in_flight  <= timing_words_q.size();
            fail_count <= mismatches;
            checked    <= beats;
            valid_seen <= n_valid;
            auto_seen  <= n_auto;
        end
    end

endmodule

@@ bench/tb_top.sv @@
// Stimulus, clock, reset and verdict for the ranging timing register encoder bench.
`timescale 1ns / 1ps

module tb_top;
    import rtre_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_FROM   = 650;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    int in_flight;
    int fail_count;
    int checked;
    int valid_seen;
    int auto_seen;
    int cycles = 0;
    int sent = 0;
    bit quiet = 1'b0;

    ranging_timing_register_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    rtre_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .in_flight  (in_flight),
        .fail_count (fail_count),
        .checked    (checked),
        .valid_seen (valid_seen),
        .auto_seen  (auto_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, in_flight);
            $display("ranging_timing_register_encoder verification failed");
            $finish;
        end
    end

    // Response side: random stall bursts, none once the tail of the run starts.
    initial
    begin : stall_gen
        int  n;
        logic on;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n  = $urandom_range(1, 16);
            on = !quiet && ($urandom_range(0, 2) == 0);
            rsp_stall <= on;
            repeat (n - 1) @(posedge clk);
        end
    end

    // Call at a rising edge; returns at the edge where the beat is taken.
    task automatic send_req(input logic [9:0] bud, input logic [15:0] per,
                            input logic [15:0] osc, input logic [15:0] cal);
        req_t r;
        r.budget_ms       = bud;
        r.period_ms       = per;
        r.osc_frequency   = osc;
        r.osc_calibration = cal;
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every pending result has drained.
    task automatic drain_pause();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    initial
    begin : stim
        logic [31:0] m;
        logic [31:0] best_m;
        logic [15:0] best_osc;
        logic [9:0]  bud;
        logic [15:0] per;
        logic [15:0] osc;
        logic [15:0] cal;
        int          sel;
        int          k;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;

        // Find the oscillator word with the largest wrapped macro period.
        best_m   = '0;
        best_osc = 16'd1;
        for (k = 1; k <= 65535; k++)
        begin
            m = (32'd2304 * (32'h4000_0000 / 32'(k))) >> 6;
            if (m > best_m)
            begin
                best_m   = m;
                best_osc = 16'(k);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Budget limits and out-of-range budgets.
        send_req(10'd0,    16'd0,     16'd3000,  16'd0);
        send_req(10'd9,    16'd0,     16'd3000,  16'd0);
        send_req(10'd10,   16'd0,     16'd3000,  16'd0);
        send_req(10'd200,  16'd0,     16'd3000,  16'd1023);
        send_req(10'd201,  16'd0,     16'd3000,  16'd0);
        send_req(10'd1023, 16'hFFFF,  16'hFFFF,  16'hFFFF);
        // Autonomous mode at both ends.
        send_req(10'd10,   16'd11,    16'd3000,  16'd1023);
        send_req(10'd200,  16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_req(10'd10,   16'hFFFF,  16'hAAAA,  16'h02AA);
        // Period not above the budget.
        send_req(10'd100,  16'd100,   16'd3000,  16'd500);
        send_req(10'd100,  16'd50,    16'd3000,  16'd500);
        send_req(10'd150,  16'd1,     16'd3000,  16'd500);
        // Zero oscillator word.
        send_req(10'd100,  16'd0,     16'd0,     16'd0);
        send_req(10'd100,  16'd200,   16'd0,     16'd77);
        // Zero divisor from a wrapped macro period, and just past it.
        send_req(10'd50,   16'd0,     16'd1,     16'd0);
        send_req(10'd50,   16'd0,     16'd64,    16'd0);
        send_req(10'd50,   16'd1000,  16'd2,     16'd300);
        send_req(10'd200,  16'd201,   16'd16,    16'h03FF);
        send_req(10'd50,   16'd0,     16'd65,    16'd0);
        // Smallest quotient: shortest budget against the largest divisor.
        send_req(10'd10,   16'd11,    best_osc,  16'd0);
        send_req(10'd10,   16'd0,     best_osc,  16'd0);
        // Calibration bits above the low ten are ignored.
        send_req(10'd33,   16'hFFFF,  16'h5555,  16'hFC00);
        send_req(10'd120,  16'h8000,  16'h0F0F,  16'hF0F0);
        drain_pause();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == QUIET_FROM)
                quiet = 1'b1;
            if (k == RANDOM_ITEMS / 2)
                drain_pause();
            else if (!quiet && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 16));

            bud = 10'($urandom_range(10, 200));
            osc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 512))
                                              : 16'($urandom_range(1, 65535));
            cal = 16'($urandom_range(0, 65535));
            sel = $urandom_range(0, 9);
            if (sel <= 2)
                per = 16'd0;
            else if (sel <= 7)
            begin
                if ($urandom_range(0, 1) == 0)
                    per = 16'(32'(bud) + 1 + $urandom_range(0, 300));
                else
                    per = 16'($urandom_range(32'(bud) + 1, 65535));
            end
            else if (sel == 8)
            begin
                bud = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 9))
                                                  : 10'($urandom_range(201, 1023));
                per = 16'($urandom_range(0, 65535));
            end
            else
            begin
                per = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(201, 65535));
                case ($urandom_range(0, 2))
                    0: per = 16'($urandom_range(1, 32'(bud)));
                    1: osc = 16'd0;
                    default: osc = 16'(1 << $urandom_range(0, 6));
                endcase
            end
            send_req(bud, per, osc, cal);
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests with stalls and drain pauses; checked %0d results,",
                 sent, checked);
        $display("of which %0d valid and %0d in autonomous mode.", valid_seen, auto_seen);
        if (fail_count == 0 && in_flight == 0)
            $display("ranging_timing_register_encoder verification clean");
        else
            $display("ranging_timing_register_encoder verification failed");
        $finish;
    end

endmodule
